[sv/vdm_pkg.sv]
// ---------------------------------------------------------------------------
// vdm_pkg: shared types and constants for the virtqueue descriptor manager
// Mode codes, result kinds and the queued command record.
// ---------------------------------------------------------------------------
`default_nettype none

package vdm_pkg;

   // input item modes
   localparam logic [1:0] MODE_POST = 2'd0;
   localparam logic [1:0] MODE_USED = 2'd1;
   localparam logic [1:0] MODE_KICK = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_DESC  = 3'd0;
   localparam logic [2:0] KIND_AVAIL = 3'd1;
   localparam logic [2:0] KIND_DONE  = 3'd2;
   localparam logic [2:0] KIND_KICK  = 3'd3;
   localparam logic [2:0] KIND_EMPTY = 3'd4;

   // additions at or past which a kick is forced
   localparam logic [15:0] FORCE_KICK_LIMIT = 16'hFFFF / 16'd2;

   typedef enum logic [1:0] {
      OP_POST,
      OP_USED,
      OP_KICK
   } op_type;

   // classified item as held in the front/back queue
   typedef struct packed {
      op_type      op;
      logic [63:0] seg_addr;
      logic [31:0] seg_len;
      logic        seg_writeable;
      logic        seg_chain_head;
      logic [7:0]  used_id;
      logic [31:0] used_len;
      logic [15:0] host_event_idx;
      logic        host_no_notify;
   } cmd_type;

   // queue output toward the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_type;

endpackage

`default_nettype wire

[sv/vdm_req_if.sv]
// ---------------------------------------------------------------------------
// vdm_req_if: input item channel
// Valid/ready channel carrying one request item per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface vdm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [63:0] seg_addr;
   logic [31:0] seg_len;
   logic        seg_writeable;
   logic        seg_chain_head;
   logic [7:0]  used_id;
   logic [31:0] used_len;
   logic [15:0] host_event_idx;
   logic        host_no_notify;

   modport source (
      output valid, mode, seg_addr, seg_len, seg_writeable, seg_chain_head,
             used_id, used_len, host_event_idx, host_no_notify,
      input  ready
   );
   modport sink (
      input  valid, mode, seg_addr, seg_len, seg_writeable, seg_chain_head,
             used_id, used_len, host_event_idx, host_no_notify,
      output ready
   );
endinterface

`default_nettype wire

[sv/vdm_rsp_if.sv]
// ---------------------------------------------------------------------------
// vdm_rsp_if: result channel
// Valid/ready channel carrying one result item per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface vdm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  desc_index;
   logic [63:0] desc_addr;
   logic [31:0] desc_len;
   logic        desc_has_next;
   logic        desc_writeable;
   logic [7:0]  desc_next;
   logic [7:0]  avail_slot;
   logic [15:0] avail_index;
   logic [31:0] done_len;
   logic        do_kick;
   logic        last;

   modport source (
      output valid, kind, desc_index, desc_addr, desc_len, desc_has_next,
             desc_writeable, desc_next, avail_slot, avail_index, done_len,
             do_kick, last,
      input  ready
   );
   modport sink (
      input  valid, kind, desc_index, desc_addr, desc_len, desc_has_next,
             desc_writeable, desc_next, avail_slot, avail_index, done_len,
             do_kick, last,
      output ready
   );
endinterface

`default_nettype wire

[sv/vdm_ram.sv]
// ---------------------------------------------------------------------------
// vdm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module vdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/vdm_front.sv]
// ---------------------------------------------------------------------------
// vdm_front: request intake
// Accepts items, decodes the mode and queues commands for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module vdm_front (
   input  wire logic           clock,
   input  wire logic           reset,
   vdm_req_if.sink             req_if,
   input  wire logic           hold,
   input  wire logic           pop,
   output vdm_pkg::queue_type  queue
);

   // two-entry queue
   vdm_pkg::cmd_type slot_ff [2];
   vdm_pkg::cmd_type slot_in [2];
   logic [1:0] count_ff, count_in;
   vdm_pkg::cmd_type cmd;
   logic accept, push;

   assign req_if.ready = !hold && (count_ff != 2'd2);
   assign accept = req_if.valid && req_if.ready;

   // decode; mode 3 is taken and dropped
   always_comb begin
      cmd.op = vdm_pkg::OP_KICK;
      case (req_if.mode)
         vdm_pkg::MODE_POST: cmd.op = vdm_pkg::OP_POST;
         vdm_pkg::MODE_USED: cmd.op = vdm_pkg::OP_USED;
         default:            cmd.op = vdm_pkg::OP_KICK;
      endcase
      cmd.seg_addr       = req_if.seg_addr;
      cmd.seg_len        = req_if.seg_len;
      cmd.seg_writeable  = req_if.seg_writeable;
      cmd.seg_chain_head = req_if.seg_chain_head;
      cmd.used_id        = req_if.used_id;
      cmd.used_len       = req_if.used_len;
      cmd.host_event_idx = req_if.host_event_idx;
      cmd.host_no_notify = req_if.host_no_notify;
   end

   assign push = accept && (req_if.mode != vdm_pkg::MODE_NONE);

   // queue update: slot 0 is the head
   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      count_in   = count_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_in - 2'd1;
      end
      if (push) begin
         if (count_in == 2'd0) begin
            slot_in[0] = cmd;
         end else begin
            slot_in[1] = cmd;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   assign queue.valid = (count_ff != 2'd0);
   assign queue.cmd   = slot_ff[0];

endmodule

`default_nettype wire

[sv/vdm_back.sv]
// ---------------------------------------------------------------------------
// vdm_back: descriptor sequencer
// Runs the free list, chain walks and kick rule; owns the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module vdm_back #(
   parameter int DESC_COUNT = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire vdm_pkg::queue_type queue,
   output      logic               pop,
   output      logic               clearing,
   input  wire logic               csr_we,
   input  wire logic               csr_wdata,
   vdm_rsp_if.source               rsp_if
);

   localparam int IW = (DESC_COUNT > 1) ? $clog2(DESC_COUNT) : 1;
   localparam int LW = IW + 1;
   localparam logic [LW-1:0] EMPTY = LW'(DESC_COUNT);
   localparam logic [LW-1:0] LAST_ENTRY = LW'(DESC_COUNT - 1);

   typedef logic [IW-1:0] mod_tab_type [256];

   // used_id modulo ring size, built by a wrapping count
   function automatic mod_tab_type build_mod();
      mod_tab_type t;
      logic [LW-1:0] v;
      v = '0;
      for (int i = 0; i < 256; i++) begin
         t[i] = v[IW-1:0];
         v = (v == LAST_ENTRY) ? '0 : v + LW'(1);
      end
      return t;
   endfunction

   localparam mod_tab_type USED_MOD = build_mod();

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_POST, S_AVAIL, S_WALK_RD, S_WALK, S_OUT
   } state_type;

   state_type state_ff, ret_ff;
   vdm_pkg::cmd_type cmd_ff;
   logic [LW-1:0] free_top_ff;
   logic [15:0]   avail_head_ff, added_ff, used_tail_ff;
   logic [IW-1:0] slot_ff, prev_ff, cur_ff, d_ff;
   logic          open_ff, evidx_ff;
   logic [LW-1:0] clr_ff, n_ff;

   // result register
   logic          rv_ff;
   logic [2:0]    kind_ff;
   logic [7:0]    index_ff, next_ff, aslot_ff;
   logic [63:0]   addr_ff;
   logic [31:0]   len_ff, done_ff;
   logic          hasnext_ff, wr_ff, kick_ff, last_ff;
   logic [15:0]   aidx_ff;

   // RAM word: {chained flag, link}
   logic          ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [LW:0]   ram_wdata, ram_rdata;
   logic [LW-1:0] rd_link;
   logic          rd_chain;

   logic [15:0] gap;
   logic        kick;

   vdm_ram #(.WIDTH(LW + 1), .DEPTH(DESC_COUNT)) u_links (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rd_link  = ram_rdata[LW-1:0];
   assign rd_chain = ram_rdata[LW];

   assign clearing = (state_ff == S_CLEAR);
   assign pop      = (state_ff == S_IDLE) && queue.valid;
   assign ram_raddr = (state_ff == S_WALK_RD) ? cur_ff : free_top_ff[IW-1:0];

   // RAM writes: clearing pass, descriptor take, descriptor release
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = d_ff;
      ram_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff[IW-1:0];
            ram_wdata = {1'b0, (clr_ff == '0) ? EMPTY : clr_ff - LW'(1)};
         end
         S_POST: begin
            ram_we    = 1'b1;
            ram_waddr = d_ff;
            ram_wdata = {open_ff, open_ff ? {1'b0, prev_ff} : {LW{1'b0}}};
         end
         S_WALK: begin
            ram_we    = 1'b1;
            ram_waddr = cur_ff;
            ram_wdata = {rd_chain, free_top_ff};
         end
         default: ram_we = 1'b0;
      endcase
   end

   // kick rule on the queued command
   always_comb begin
      gap  = avail_head_ff - queue.cmd.host_event_idx - 16'd1;
      kick = 1'b0;
      if (evidx_ff) begin
         kick = (gap < added_ff) || (added_ff >= vdm_pkg::FORCE_KICK_LIMIT);
      end else begin
         kick = !queue.cmd.host_no_notify;
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ret_ff        <= S_IDLE;
         free_top_ff   <= LAST_ENTRY;
         avail_head_ff <= '0;
         added_ff      <= '0;
         used_tail_ff  <= '0;
         slot_ff       <= '0;
         prev_ff       <= '0;
         open_ff       <= 1'b0;
         evidx_ff      <= 1'b1;
         clr_ff        <= '0;
         rv_ff         <= 1'b0;
      end else begin
         if (csr_we) begin
            evidx_ff <= csr_wdata;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + LW'(1);
               if (clr_ff == LAST_ENTRY) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (queue.valid) begin
                  cmd_ff     <= queue.cmd;
                  kind_ff    <= vdm_pkg::KIND_DONE;
                  index_ff   <= '0;
                  addr_ff    <= '0;
                  len_ff     <= '0;
                  hasnext_ff <= 1'b0;
                  wr_ff      <= 1'b0;
                  next_ff    <= '0;
                  aslot_ff   <= '0;
                  aidx_ff    <= '0;
                  done_ff    <= '0;
                  kick_ff    <= 1'b0;
                  last_ff    <= 1'b1;
                  case (queue.cmd.op)
                     vdm_pkg::OP_POST: begin
                        if (free_top_ff == EMPTY) begin
                           kind_ff  <= vdm_pkg::KIND_EMPTY;
                           open_ff  <= 1'b0;
                           prev_ff  <= '0;
                           rv_ff    <= 1'b1;
                           ret_ff   <= S_IDLE;
                           state_ff <= S_OUT;
                        end else begin
                           d_ff     <= free_top_ff[IW-1:0];
                           state_ff <= S_POST;
                        end
                     end
                     vdm_pkg::OP_USED: begin
                        kind_ff      <= vdm_pkg::KIND_DONE;
                        index_ff     <= queue.cmd.used_id;
                        done_ff      <= queue.cmd.used_len;
                        used_tail_ff <= used_tail_ff + 16'd1;
                        cur_ff       <= USED_MOD[queue.cmd.used_id];
                        n_ff         <= '0;
                        rv_ff        <= 1'b1;
                        ret_ff       <= S_WALK_RD;
                        state_ff     <= S_OUT;
                     end
                     default: begin
                        kind_ff <= vdm_pkg::KIND_KICK;
                        kick_ff <= kick;
                        if (kick) begin
                           added_ff <= '0;
                        end
                        rv_ff    <= 1'b1;
                        ret_ff   <= S_IDLE;
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_POST: begin
               // link word of the taken descriptor is now on the read port
               free_top_ff <= rd_link;
               kind_ff     <= vdm_pkg::KIND_DESC;
               index_ff    <= 8'(d_ff);
               addr_ff     <= cmd_ff.seg_addr;
               len_ff      <= cmd_ff.seg_len;
               hasnext_ff  <= open_ff;
               wr_ff       <= cmd_ff.seg_writeable;
               next_ff     <= open_ff ? 8'(prev_ff) : 8'd0;
               last_ff     <= !cmd_ff.seg_chain_head;
               rv_ff       <= 1'b1;
               state_ff    <= S_OUT;
               if (cmd_ff.seg_chain_head) begin
                  ret_ff <= S_AVAIL;
               end else begin
                  open_ff <= 1'b1;
                  prev_ff <= d_ff;
                  ret_ff  <= S_IDLE;
               end
            end
            S_AVAIL: begin
               kind_ff       <= vdm_pkg::KIND_AVAIL;
               index_ff      <= 8'(d_ff);
               addr_ff       <= '0;
               len_ff        <= '0;
               hasnext_ff    <= 1'b0;
               wr_ff         <= 1'b0;
               next_ff       <= '0;
               aslot_ff      <= 8'(slot_ff);
               aidx_ff       <= avail_head_ff + 16'd1;
               last_ff       <= 1'b1;
               avail_head_ff <= avail_head_ff + 16'd1;
               added_ff      <= added_ff + 16'd1;
               // slot tracks avail_head modulo ring size across 16-bit wrap
               if (avail_head_ff == 16'hFFFF ||
                   {1'b0, slot_ff} == LAST_ENTRY) begin
                  slot_ff <= '0;
               end else begin
                  slot_ff <= slot_ff + IW'(1);
               end
               open_ff  <= 1'b0;
               prev_ff  <= '0;
               rv_ff    <= 1'b1;
               ret_ff   <= S_IDLE;
               state_ff <= S_OUT;
            end
            S_WALK_RD: begin
               state_ff <= S_WALK;
            end
            S_WALK: begin
               // release cur onto the free list, follow the chain
               free_top_ff <= {1'b0, cur_ff};
               if (!rd_chain || rd_link >= EMPTY || n_ff == LAST_ENTRY) begin
                  state_ff <= S_IDLE;
               end else begin
                  cur_ff   <= rd_link[IW-1:0];
                  n_ff     <= n_ff + LW'(1);
                  state_ff <= S_WALK_RD;
               end
            end
            S_OUT: begin
               if (rsp_if.ready) begin
                  rv_ff    <= 1'b0;
                  state_ff <= ret_ff;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_if.valid          = rv_ff;
   assign rsp_if.kind           = kind_ff;
   assign rsp_if.desc_index     = index_ff;
   assign rsp_if.desc_addr      = addr_ff;
   assign rsp_if.desc_len       = len_ff;
   assign rsp_if.desc_has_next  = hasnext_ff;
   assign rsp_if.desc_writeable = wr_ff;
   assign rsp_if.desc_next      = next_ff;
   assign rsp_if.avail_slot     = aslot_ff;
   assign rsp_if.avail_index    = aidx_ff;
   assign rsp_if.done_len       = done_ff;
   assign rsp_if.do_kick        = kick_ff;
   assign rsp_if.last           = last_ff;

endmodule

`default_nettype wire

[sv/virtqueue_descriptor_manager_top.sv]
// Sequence: a post takes a descriptor off the free list and gives its result,
//   then the avail entry for a chain head; a used element gives its completion,
//   then walks its chain back onto the free list, one link-store read and write
//   per descriptor. The front queue holds up to two items while this runs.
// Reset: synchronous; the link store is then swept entry by entry, during
//   which no item is taken (configuration writes still are).
// ---------------------------------------------------------------------------
// virtqueue_descriptor_manager_top: split virtqueue driver bookkeeping
// Front queue of decoded items feeding the descriptor sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module virtqueue_descriptor_manager_top #(
   parameter int DESC_COUNT = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   vdm_req_if.sink   req_if,
   vdm_rsp_if.source rsp_if,
   input  wire logic csr_we,
   input  wire logic csr_wdata
);

   vdm_pkg::queue_type queue;
   logic pop, clearing;

   // intake and decode
   vdm_front u_front (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .hold  (clearing),
      .pop   (pop),
      .queue (queue)
   );

   // descriptor sequencer
   vdm_back #(.DESC_COUNT(DESC_COUNT)) u_back (
      .clock    (clock),
      .reset    (reset),
      .queue    (queue),
      .pop      (pop),
      .clearing (clearing),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .rsp_if   (rsp_if)
   );

`ifndef SYNTHESIS
   a_no_take_in_clear: assert property (@(posedge clock)
      clearing |-> !req_if.ready) else $error("item taken during clear");
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_if.valid) else $error("result during clear");
   a_queue_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !queue.valid) else $error("queue not empty after reset");
   a_pop_only_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> queue.valid && !clearing) else $error("pop of empty queue");
   a_single_results_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.kind == vdm_pkg::KIND_EMPTY ||
      rsp_if.kind == vdm_pkg::KIND_KICK) |-> rsp_if.last)
      else $error("single result without last");
`endif

endmodule

`default_nettype wire

[sim/virtqueue_descriptor_manager_top_test.sv]
// ---------------------------------------------------------------------------
// virtqueue_descriptor_manager_top_test: descriptor manager testbench
// Drives post, used-element and kick items with random gaps and output
// stalls. A local model predicts every result from the accepted items.
// Covers the event-index and host-flag kick rules, free-list exhaustion,
// broken chains and stray returns.
// ---------------------------------------------------------------------------
`default_nettype none

module virtqueue_descriptor_manager_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NDESC     = 256;
   localparam int NUM_ITEMS = 1550;

   typedef struct {
      logic [1:0]  mode;
      logic [63:0] seg_addr;
      logic [31:0] seg_len;
      logic        seg_writeable;
      logic        seg_chain_head;
      logic [7:0]  used_id;
      logic [31:0] used_len;
      logic [15:0] host_event_idx;
      logic        host_no_notify;
   } vq_item_type;

   typedef struct {
      logic [2:0]  kind;
      logic [7:0]  desc_index;
      logic [63:0] desc_addr;
      logic [31:0] desc_len;
      logic        desc_has_next;
      logic        desc_writeable;
      logic [7:0]  desc_next;
      logic [7:0]  avail_slot;
      logic [15:0] avail_index;
      logic [31:0] done_len;
      logic        do_kick;
      logic        last;
   } vq_result_type;

   // Descriptor bookkeeping model and pending result store
   class vq_scoreboard;
      logic [8:0]    link_mem[NDESC];
      bit            chain_bit[NDESC];
      logic [8:0]    free_head;
      logic [15:0]   avail_ptr;
      logic [15:0]   added_cnt;
      logic [15:0]   used_cnt;
      logic [7:0]    open_prev;
      bit            open_chain;
      bit            event_idx_en;
      int            last_head;
      int            mismatches;
      vq_result_type pending_results[$];

      function new();
         for (int i = 0; i < NDESC; i++) begin
            link_mem[i]  = (i == 0) ? 9'(NDESC) : 9'(i - 1);
            chain_bit[i] = 0;
         end
         free_head    = 9'(NDESC - 1);
         avail_ptr    = 0;
         added_cnt    = 0;
         used_cnt     = 0;
         open_prev    = 0;
         open_chain   = 0;
         event_idx_en = 1;
         last_head    = -1;
         mismatches   = 0;
      endfunction

      function vq_result_type blank();
         vq_result_type r;
         r = '{default: '0};
         return r;
      endfunction

      function void add_result(vq_result_type r);
         pending_results.insert(pending_results.size(), r);
      endfunction

      // predict the results of one accepted transfer
      function void note_item(vq_item_type it);
         vq_result_type r;
         logic [7:0]    d;
         logic [7:0]    cur;
         logic [8:0]    nxt;
         bit            more;
         bit            kick;
         logic [15:0]   gap;
         last_head = -1;
         case (it.mode)
            vdm_pkg::MODE_POST: begin
               r = blank();
               if (free_head >= NDESC) begin
                  r.kind = vdm_pkg::KIND_EMPTY;
                  r.last = 1;
                  add_result(r);
                  open_chain = 0;
                  open_prev  = 0;
               end else begin
                  d = free_head[7:0];
                  free_head = link_mem[d];
                  r.kind           = vdm_pkg::KIND_DESC;
                  r.desc_index     = d;
                  r.desc_addr      = it.seg_addr;
                  r.desc_len       = it.seg_len;
                  r.desc_has_next  = open_chain;
                  r.desc_writeable = it.seg_writeable;
                  r.desc_next      = open_chain ? open_prev : 8'd0;
                  r.last           = !it.seg_chain_head;
                  add_result(r);
                  link_mem[d]  = open_chain ? {1'b0, open_prev} : 9'd0;
                  chain_bit[d] = open_chain;
                  if (!it.seg_chain_head) begin
                     open_chain = 1;
                     open_prev  = d;
                  end else begin
                     r = blank();
                     r.kind        = vdm_pkg::KIND_AVAIL;
                     r.desc_index  = d;
                     r.avail_slot  = avail_ptr[7:0];
                     avail_ptr     = avail_ptr + 16'd1;
                     added_cnt     = added_cnt + 16'd1;
                     r.avail_index = avail_ptr;
                     r.last        = 1;
                     add_result(r);
                     open_chain = 0;
                     open_prev  = 0;
                     last_head  = int'(d);
                  end
               end
            end
            vdm_pkg::MODE_USED: begin
               r = blank();
               r.kind       = vdm_pkg::KIND_DONE;
               r.desc_index = it.used_id;
               r.done_len   = it.used_len;
               r.last       = 1;
               add_result(r);
               used_cnt = used_cnt + 16'd1;
               // walk the chain back onto the free list
               cur = it.used_id;
               for (int n = 0; n < NDESC; n++) begin
                  nxt  = link_mem[cur];
                  more = chain_bit[cur];
                  link_mem[cur] = free_head;
                  free_head     = {1'b0, cur};
                  if (!more || nxt >= NDESC) break;
                  cur = nxt[7:0];
               end
            end
            vdm_pkg::MODE_KICK: begin
               r = blank();
               r.kind = vdm_pkg::KIND_KICK;
               r.last = 1;
               if (event_idx_en) begin
                  gap  = avail_ptr - it.host_event_idx - 16'd1;
                  kick = (gap < added_cnt) ||
                         (added_cnt >= vdm_pkg::FORCE_KICK_LIMIT);
               end else begin
                  kick = !it.host_no_notify;
               end
               if (kick) added_cnt = 0;
               r.do_kick = kick;
               add_result(r);
            end
            default: ;
         endcase
      endfunction

      // compare one result transfer with the oldest prediction
      function void check_result(vq_result_type got);
         vq_result_type exp_r;
         string         bad;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result %p", got);
            return;
         end
         exp_r = pending_results.pop_front();
         bad = "";
         if (got.kind !== exp_r.kind) bad = {bad, " kind"};
         if (got.desc_index !== exp_r.desc_index) bad = {bad, " desc_index"};
         if (got.desc_addr !== exp_r.desc_addr) bad = {bad, " desc_addr"};
         if (got.desc_len !== exp_r.desc_len) bad = {bad, " desc_len"};
         if (got.desc_has_next !== exp_r.desc_has_next) bad = {bad, " desc_has_next"};
         if (got.desc_writeable !== exp_r.desc_writeable) bad = {bad, " desc_writeable"};
         if (got.desc_next !== exp_r.desc_next) bad = {bad, " desc_next"};
         if (got.avail_slot !== exp_r.avail_slot) bad = {bad, " avail_slot"};
         if (got.avail_index !== exp_r.avail_index) bad = {bad, " avail_index"};
         if (got.done_len !== exp_r.done_len) bad = {bad, " done_len"};
         if (got.do_kick !== exp_r.do_kick) bad = {bad, " do_kick"};
         if (got.last !== exp_r.last) bad = {bad, " last"};
         if (bad != "") begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: mismatch in%s\n  expected %p\n  actual   %p",
                        bad, exp_r, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   vdm_req_if req_if ();
   vdm_rsp_if rsp_if ();

   virtqueue_descriptor_manager_top #(.DESC_COUNT(NDESC)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   vq_scoreboard sb = new();
   bit           gaps_on;
   bit           long_hold;
   int           sent_count = 0;
   int           outstanding_heads[$];

   // clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #100ms;
      $display("virtqueue_descriptor_manager_top_test failed");
      $finish;
   end

   // result side: random stall bursts plus one long hold-off
   initial begin
      forever begin
         if (long_hold) begin
            long_hold = 0;
            rsp_if.ready <= 0;
            repeat (400) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1;
            @(posedge clock);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      vq_result_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.kind           = rsp_if.kind;
         got.desc_index     = rsp_if.desc_index;
         got.desc_addr      = rsp_if.desc_addr;
         got.desc_len       = rsp_if.desc_len;
         got.desc_has_next  = rsp_if.desc_has_next;
         got.desc_writeable = rsp_if.desc_writeable;
         got.desc_next      = rsp_if.desc_next;
         got.avail_slot     = rsp_if.avail_slot;
         got.avail_index    = rsp_if.avail_index;
         got.done_len       = rsp_if.done_len;
         got.do_kick        = rsp_if.do_kick;
         got.last           = rsp_if.last;
         sb.check_result(got);
      end
   end

   // offer one item and hold it until the transfer
   task automatic send_item(vq_item_type it);
      req_if.valid          <= 1;
      req_if.mode           <= it.mode;
      req_if.seg_addr       <= it.seg_addr;
      req_if.seg_len        <= it.seg_len;
      req_if.seg_writeable  <= it.seg_writeable;
      req_if.seg_chain_head <= it.seg_chain_head;
      req_if.used_id        <= it.used_id;
      req_if.used_len       <= it.used_len;
      req_if.host_event_idx <= it.host_event_idx;
      req_if.host_no_notify <= it.host_no_notify;
      do @(posedge clock); while (!req_if.ready);
      sb.note_item(it);
      sent_count++;
      if (sb.last_head >= 0)
         outstanding_heads.insert(outstanding_heads.size(), sb.last_head);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   function automatic vq_item_type random_item(logic [1:0] mode);
      vq_item_type it;
      it.mode           = mode;
      it.seg_addr       = {$urandom, $urandom};
      it.seg_len        = $urandom;
      it.seg_writeable  = 1'($urandom_range(0, 1));
      it.seg_chain_head = 1'($urandom_range(0, 1));
      it.used_id        = 8'($urandom);
      it.used_len       = $urandom;
      it.host_event_idx = 16'($urandom);
      it.host_no_notify = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // post a whole chain, tail segment first
   task automatic post_chain(int nseg);
      vq_item_type it;
      for (int s = 0; s < nseg; s++) begin
         it = random_item(vdm_pkg::MODE_POST);
         it.seg_chain_head = (s == nseg - 1);
         send_item(it);
      end
   endtask

   // hand back one outstanding chain, picked at random
   task automatic return_chain();
      vq_item_type it;
      int          k;
      if (outstanding_heads.size() == 0) return;
      k = $urandom_range(0, outstanding_heads.size() - 1);
      it = random_item(vdm_pkg::MODE_USED);
      it.used_id = 8'(outstanding_heads[k]);
      outstanding_heads.delete(k);
      send_item(it);
   endtask

   // kick check, mostly with an event index near the avail index
   task automatic kick_check();
      vq_item_type it;
      it = random_item(vdm_pkg::MODE_KICK);
      if ($urandom_range(0, 3) != 0)
         it.host_event_idx = sb.avail_ptr - 16'($urandom_range(0, 6));
      send_item(it);
   endtask

   task automatic drain_results();
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // register write with the block idle
   task automatic write_csr(bit value);
      req_if.valid <= 0;
      drain_results();
      repeat (600) @(posedge clock);
      csr_we    <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      sb.event_idx_en = value;
   endtask

   // stimulus
   initial begin
      vq_item_type it;
      int          sel;
      bit          exhaust_done;
      req_if.valid          <= 0;
      req_if.mode           <= vdm_pkg::MODE_POST;
      req_if.seg_addr       <= '0;
      req_if.seg_len        <= '0;
      req_if.seg_writeable  <= 0;
      req_if.seg_chain_head <= 0;
      req_if.used_id        <= '0;
      req_if.used_len       <= '0;
      req_if.host_event_idx <= '0;
      req_if.host_no_notify <= 0;
      csr_we    <= 0;
      csr_wdata <= 0;
      gaps_on      = 0;
      long_hold    = 0;
      exhaust_done = 0;
      reset     <= 1;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: field extremes and each operation
      it = random_item(vdm_pkg::MODE_POST);
      it.seg_addr = '1; it.seg_len = '1; it.seg_writeable = 1; it.seg_chain_head = 1;
      send_item(it);
      it.seg_addr = '0; it.seg_len = '0; it.seg_writeable = 0; it.seg_chain_head = 0;
      send_item(it);
      it.seg_writeable = 1;
      send_item(it);
      it.seg_chain_head = 1;
      send_item(it);
      it = random_item(vdm_pkg::MODE_KICK);
      it.host_event_idx = 16'hFFFF;
      send_item(it);
      it.host_event_idx = sb.avail_ptr - 16'd1;
      send_item(it);
      it.host_event_idx = 16'h0000;
      send_item(it);
      it = random_item(vdm_pkg::MODE_NONE);
      send_item(it);
      it = random_item(vdm_pkg::MODE_USED);
      it.used_id = 8'(outstanding_heads.pop_back()); it.used_len = '1;
      send_item(it);
      it.used_id = 8'(outstanding_heads.pop_back()); it.used_len = '0;
      send_item(it);
      write_csr(0);
      it = random_item(vdm_pkg::MODE_KICK);
      it.host_no_notify = 0;
      send_item(it);
      it.host_no_notify = 1;
      send_item(it);
      write_csr(1);
      it = random_item(vdm_pkg::MODE_KICK);
      it.host_event_idx = sb.avail_ptr;
      send_item(it);

      // random part, opened by a long output hold-off
      gaps_on   = 1;
      long_hold = 1;
      while (sent_count < NUM_ITEMS) begin
         if (!exhaust_done && sent_count >= NUM_ITEMS / 3) begin
            // exhaust the free list, then give everything back
            exhaust_done = 1;
            for (int c = 0; c < 160 && sb.free_head < NDESC; c++)
               post_chain($urandom_range(1, 4));
            post_chain(2);
            while (outstanding_heads.size() != 0) return_chain();
            write_csr(0);
         end
         if (sent_count >= (NUM_ITEMS * 4) / 5) gaps_on = 0;
         sel = $urandom_range(0, 99);
         if (sel < 45 && outstanding_heads.size() < 40) begin
            post_chain($urandom_range(1, 4));
         end else if (sel < 75) begin
            return_chain();
         end else if (sel < 88) begin
            kick_check();
         end else if (sel < 93) begin
            // chain left open, then other items
            it = random_item(vdm_pkg::MODE_POST);
            it.seg_chain_head = 0;
            send_item(it);
         end else if (sel < 96) begin
            // return of a chain that is not outstanding
            send_item(random_item(vdm_pkg::MODE_USED));
         end else if (sel < 98 || !gaps_on) begin
            send_item(random_item(vdm_pkg::MODE_NONE));
         end else begin
            write_csr(1'($urandom_range(0, 1)));
         end
      end
      req_if.valid <= 0;

      drain_results();
      repeat (600) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0)
         $display("virtqueue_descriptor_manager_top_test passed");
      else
         $display("virtqueue_descriptor_manager_top_test failed");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
sv/vdm_pkg.sv
sv/vdm_req_if.sv
sv/vdm_rsp_if.sv
sv/vdm_ram.sv
sv/vdm_front.sv
sv/vdm_back.sv
sv/virtqueue_descriptor_manager_top.sv
sim/virtqueue_descriptor_manager_top_test.sv
